[sv/bsr_pkg.sv]
`timescale 1ns / 1ps

package bsr_pkg;

	localparam int DATA_W      = 32;
	localparam int FRAC_BITS   = 16;
	localparam int MAX_GUESSES = 64;
	localparam int CNT_W       = 7;
	localparam int SQ_W        = 2 * DATA_W;
	localparam int ADDR_W      = 3;

	localparam logic [DATA_W-1:0] TOL_RESET = DATA_W'(66);
	localparam logic [DATA_W-1:0] ONE_FX    = DATA_W'(1) << FRAC_BITS;
	localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_GUESSES);

	// register index as decoded from paddr[2]
	localparam logic REG_TOLERANCE = 1'b0;

	typedef struct packed {
		logic            gt;
		logic [SQ_W-1:0] err;
	} bsr_err_t;

endpackage

[sv/bsr_in_if.sv]
`timescale 1ns / 1ps

interface bsr_in_if;
	logic                        valid;
	logic                        ready;
	logic [bsr_pkg::DATA_W-1:0]  x_value;

	modport source (output valid, output x_value, input ready);
	modport sink   (input valid, input x_value, output ready);
endinterface

[sv/bsr_out_if.sv]
`timescale 1ns / 1ps

interface bsr_out_if;
	logic                        valid;
	logic                        ready;
	logic [bsr_pkg::DATA_W-1:0]  root;
	logic [bsr_pkg::CNT_W-1:0]   guess_count;
	logic                        converged;

	modport source (output valid, output root, output guess_count, output converged, input ready);
	modport sink   (input valid, input root, input guess_count, input converged, output ready);
endinterface

[sv/bsr_apb_regs.sv]
`timescale 1ns / 1ps

module bsr_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bsr_pkg::ADDR_W-1:0]  paddr,
	input  logic [bsr_pkg::DATA_W-1:0]  pwdata,
	output logic [bsr_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output logic [bsr_pkg::DATA_W-1:0]  tolerance
);

	logic [bsr_pkg::DATA_W-1:0] tol_q;
	logic                       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == bsr_pkg::REG_TOLERANCE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= bsr_pkg::TOL_RESET;
		end else if (wr_en) begin
			tol_q <= pwdata;
		end
	end

	always_comb begin
		if (paddr[2] == bsr_pkg::REG_TOLERANCE) begin
			prdata = tol_q;
		end else begin
			prdata = '0;
		end
	end

	assign tolerance = tol_q;

endmodule

[sv/bsr_sq_unit.sv]
`timescale 1ns / 1ps

// Two-stage squaring and error unit: stage 1 squares the guess,
// stage 2 forms the absolute difference against the target.
module bsr_sq_unit (
	input  logic                        clk,
	input  logic [bsr_pkg::DATA_W-1:0]  guess,
	input  logic [bsr_pkg::SQ_W-1:0]    target,
	output bsr_pkg::bsr_err_t           stat
);

	logic [bsr_pkg::SQ_W-1:0] sq_w;
	logic [bsr_pkg::SQ_W-1:0] sq_s1;
	logic                     gt_w;
	bsr_pkg::bsr_err_t        stat_s2;

	assign sq_w = {{bsr_pkg::DATA_W{1'b0}}, guess} * {{bsr_pkg::DATA_W{1'b0}}, guess};
	assign gt_w = sq_s1 > target;

	always_ff @(posedge clk) begin
		sq_s1       <= sq_w;
		stat_s2.gt  <= gt_w;
		stat_s2.err <= gt_w ? (sq_s1 - target) : (target - sq_s1);
	end

	assign stat = stat_s2;

endmodule

[sv/bsr_seq.sv]
`timescale 1ns / 1ps

module bsr_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bsr_pkg::DATA_W-1:0]  tolerance,
	bsr_in_if.sink                      operand,
	bsr_out_if.source                   result,
	input  bsr_pkg::bsr_err_t           stat,
	output logic [bsr_pkg::DATA_W-1:0]  guess,
	output logic [bsr_pkg::SQ_W-1:0]    target
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ERR,
		S_DEC,
		S_OUT
	} state_t;

	state_t                     state_q;
	logic [bsr_pkg::DATA_W-1:0] x_q;
	logic [bsr_pkg::DATA_W-1:0] lo_q;
	logic [bsr_pkg::DATA_W-1:0] hi_q;
	logic [bsr_pkg::DATA_W-1:0] guess_q;
	logic [bsr_pkg::CNT_W-1:0]  step_q;
	logic                       conv_q;

	logic [bsr_pkg::DATA_W-1:0] hi_init;
	logic [bsr_pkg::DATA_W:0]   sum_lo;
	logic [bsr_pkg::DATA_W:0]   sum_hi;
	logic [bsr_pkg::SQ_W-1:0]   limit;
	logic                       below;

	assign hi_init = (operand.x_value > bsr_pkg::ONE_FX) ? operand.x_value : bsr_pkg::ONE_FX;
	// midpoints for keeping the lower half or the upper half, 33-bit sums
	assign sum_lo  = {1'b0, lo_q} + {1'b0, guess_q};
	assign sum_hi  = {1'b0, guess_q} + {1'b0, hi_q};
	assign limit   = {{(bsr_pkg::SQ_W - bsr_pkg::DATA_W - bsr_pkg::FRAC_BITS){1'b0}},
		tolerance, {bsr_pkg::FRAC_BITS{1'b0}}};
	assign below   = stat.err < limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			x_q     <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			guess_q <= '0;
			step_q  <= '0;
			conv_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (operand.valid) begin
						x_q     <= operand.x_value;
						lo_q    <= '0;
						hi_q    <= hi_init;
						guess_q <= hi_init >> 1;
						step_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_ERR;
				S_ERR: state_q <= S_DEC;
				S_DEC: begin
					if (below || step_q == bsr_pkg::CNT_MAX) begin
						conv_q  <= below;
						state_q <= S_OUT;
					end else begin
						// drop the half that cannot hold the root
						if (stat.gt) begin
							hi_q    <= guess_q;
							guess_q <= sum_lo[bsr_pkg::DATA_W:1];
						end else begin
							lo_q    <= guess_q;
							guess_q <= sum_hi[bsr_pkg::DATA_W:1];
						end
						step_q  <= step_q + bsr_pkg::CNT_W'(1);
						state_q <= S_MUL;
					end
				end
				S_OUT: begin
					if (result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign operand.ready      = (state_q == S_IDLE);
	assign result.valid       = (state_q == S_OUT);
	assign result.root        = guess_q;
	assign result.guess_count = step_q;
	assign result.converged   = conv_q;

	assign guess  = guess_q;
	assign target = {{(bsr_pkg::SQ_W - bsr_pkg::DATA_W - bsr_pkg::FRAC_BITS){1'b0}},
		x_q, {bsr_pkg::FRAC_BITS{1'b0}}};

endmodule

[sv/bisection_square_root_unit.sv]
`timescale 1ns / 1ps

// Each guess passes through a squaring, an error and a decision state of the
// sequencer, using the shared two-stage squaring unit; n = guess_count runs
// 0..64, and the result goes valid once a decision ends the search.
// Throughput: one root at a time; the next operand is taken the cycle after the
// result transfer. Reset (arst_n low, asynchronous) idles the sequencer and
// sets tolerance to 66.
module bisection_square_root_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bsr_pkg::ADDR_W-1:0]  paddr,
	input  logic [bsr_pkg::DATA_W-1:0]  pwdata,
	output logic [bsr_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	bsr_in_if.sink                      operand,
	bsr_out_if.source                   result
);

	logic [bsr_pkg::DATA_W-1:0] tolerance;
	logic [bsr_pkg::DATA_W-1:0] guess;
	logic [bsr_pkg::SQ_W-1:0]   target;
	bsr_pkg::bsr_err_t          stat;

	bsr_apb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.tolerance (tolerance)
	);

	bsr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.tolerance (tolerance),
		.operand   (operand),
		.result    (result),
		.stat      (stat),
		.guess     (guess),
		.target    (target)
	);

	bsr_sq_unit u_sq (
		.clk    (clk),
		.guess  (guess),
		.target (target),
		.stat   (stat)
	);

endmodule

[sv/bsr_checker.sv]
`timescale 1ns / 1ps

module bsr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        op_valid,
	input logic                        op_ready,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [bsr_pkg::DATA_W-1:0]  res_root,
	input logic [bsr_pkg::CNT_W-1:0]   res_count,
	input logic                        res_conv
);

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && op_ready |=> !op_ready && !res_valid)
		else $error("operand taken while a root is in progress");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_root))
		else $error("stalled result changed");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_count <= bsr_pkg::CNT_MAX)
		else $error("guess count beyond cap");

	a_cap_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_conv |-> res_count == bsr_pkg::CNT_MAX)
		else $error("search ended early without converging");

	a_no_take_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !op_ready)
		else $error("ready for operand while result pending");

endmodule

bind bisection_square_root_unit bsr_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.op_valid  (operand.valid),
	.op_ready  (operand.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_root  (result.root),
	.res_count (result.guess_count),
	.res_conv  (result.converged)
);

[sim/tb_bisection_square_root_unit.sv]
`timescale 1ns / 1ps

module tb_bisection_square_root_unit;
	import bsr_pkg::*;

	typedef enum logic [1:0] {
		PH_STEADY,
		PH_SRC_GAPS,
		PH_SINK_STALLS,
		PH_MIXED
	} pace_t;

	typedef enum logic {
		ROW_OPERAND,
		ROW_TOLERANCE
	} row_kind_t;

	typedef struct packed {
		logic [DATA_W-1:0] root;
		logic [CNT_W-1:0]  guess_count;
		logic              converged;
	} root_result_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [DATA_W-1:0] value;
		logic              typed;
		root_result_t      want;
	} script_row_t;

	localparam logic [ADDR_W-1:0] TOL_ADDR = {REG_TOLERANCE, 2'b00};
	localparam root_result_t NO_WANT = '0;
	localparam int SCRIPT_LEN = 21;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 235;
	localparam int HOLD_CYCLES = 800;
	localparam int TAIL_CYCLES = 200;
	localparam int QUIET_LIMIT = 4000;
	localparam int MAX_REPORTS = 20;

	// Typed results: zero input walks the guess down by halves; an exact square
	// lands on the first midpoint; a huge tolerance takes the first guess.
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{ROW_OPERAND,   32'h0000_0000, 1'b1, '{32'h0000_0800, 7'd4, 1'b1}},
		'{ROW_OPERAND,   32'h0004_0000, 1'b1, '{32'h0002_0000, 7'd0, 1'b1}},
		'{ROW_OPERAND,   32'hFFFF_FFFF, 1'b0, NO_WANT},
		'{ROW_OPERAND,   32'h0001_0000, 1'b0, NO_WANT},
		'{ROW_OPERAND,   32'h0000_0001, 1'b0, NO_WANT},
		'{ROW_OPERAND,   32'h0000_8000, 1'b0, NO_WANT},
		'{ROW_OPERAND,   32'h0009_0000, 1'b0, NO_WANT},
		'{ROW_OPERAND,   32'hAAAA_5555, 1'b0, NO_WANT},
		'{ROW_TOLERANCE, 32'h0000_0000, 1'b0, NO_WANT},
		'{ROW_OPERAND,   32'h0004_0000, 1'b0, NO_WANT},
		'{ROW_OPERAND,   32'h0000_0000, 1'b0, NO_WANT},
		'{ROW_OPERAND,   32'hFFFF_FFFF, 1'b0, NO_WANT},
		'{ROW_TOLERANCE, 32'hFFFF_FFFF, 1'b0, NO_WANT},
		'{ROW_OPERAND,   32'h0000_0000, 1'b1, '{32'h0000_8000, 7'd0, 1'b1}},
		'{ROW_OPERAND,   32'hFFFF_FFFF, 1'b0, NO_WANT},
		'{ROW_OPERAND,   32'h0004_0000, 1'b1, '{32'h0002_0000, 7'd0, 1'b1}},
		'{ROW_TOLERANCE, 32'h0000_0001, 1'b0, NO_WANT},
		'{ROW_OPERAND,   32'h0004_0000, 1'b1, '{32'h0002_0000, 7'd0, 1'b1}},
		'{ROW_OPERAND,   32'h5555_5555, 1'b0, NO_WANT},
		'{ROW_OPERAND,   32'h0002_0000, 1'b0, NO_WANT},
		'{ROW_TOLERANCE, TOL_RESET,     1'b0, NO_WANT}
	};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	bsr_in_if  op_if ();
	bsr_out_if res_if ();

	bisection_square_root_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.operand (op_if.sink),
		.result  (res_if.source)
	);

	root_result_t pending_roots [$];
	logic [DATA_W-1:0] tol_shadow;
	pace_t pace;
	int mismatches;
	int operands_sent;
	int tol_writes;
	int roots_seen;
	int roots_capped;
	int hold_asks;
	int holds_taken;
	int hold_left;
	root_result_t got_root;
	root_result_t want_root;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Bisect with exact 64-bit squares; the bound sum is 33 bits wide.
	function automatic root_result_t bisect_root(input logic [DATA_W-1:0] x,
			input logic [DATA_W-1:0] tol);
		logic [SQ_W-1:0]   target;
		logic [SQ_W-1:0]   limit;
		logic [SQ_W-1:0]   sq;
		logic [SQ_W-1:0]   err;
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] hi;
		logic [DATA_W-1:0] g;
		logic [DATA_W:0]   sum;
		logic [CNT_W-1:0]  n;
		root_result_t      r;
		target = SQ_W'(x) << FRAC_BITS;
		limit = SQ_W'(tol) << FRAC_BITS;
		lo = '0;
		hi = (x > ONE_FX) ? x : ONE_FX;
		n = '0;
		forever begin
			sum = {1'b0, lo} + {1'b0, hi};
			g = sum[DATA_W:1];
			sq = SQ_W'(g) * SQ_W'(g);
			err = (sq >= target) ? sq - target : target - sq;
			if (err < limit || n == CNT_MAX)
				break;
			if (sq > target)
				hi = g;
			else
				lo = g;
			n++;
		end
		r.root = g;
		r.guess_count = n;
		r.converged = (err < limit);
		return r;
	endfunction

	function automatic int src_gap_pct(input pace_t p);
		case (p)
			PH_SRC_GAPS: return 78;
			PH_MIXED: return 26;
			default: return 0;
		endcase
	endfunction

	function automatic int sink_stall_pct(input pace_t p);
		case (p)
			PH_SINK_STALLS: return 78;
			PH_MIXED: return 26;
			default: return 0;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_operand();
		logic [15:0] k;
		k = 16'($urandom_range(0, 16'hFFFF));
		case ($urandom_range(0, 5))
			0: return DATA_W'($urandom_range(0, 32'h0002_FFFF));
			1: return DATA_W'(k) * DATA_W'(k);
			2: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
			3: return 32'hFFFF_FFFF - DATA_W'($urandom_range(0, 255));
			default: return DATA_W'($urandom);
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] phase_tolerance(input int p);
		case (p)
			0: return TOL_RESET;
			1: return '0;
			2: return DATA_W'(1);
			3: return DATA_W'($urandom);
			4: return '1;
			5: return DATA_W'($urandom_range(1, 16'hFFFF));
			6: return ONE_FX;
			default: return DATA_W'($urandom_range(2, 300));
		endcase
	endfunction

	task automatic note_mismatch(input string msg);
		if (mismatches < MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic send_operand(input logic [DATA_W-1:0] x, input root_result_t want);
		int gap_pct;
		gap_pct = src_gap_pct(pace);
		while ($urandom_range(0, 99) < gap_pct) begin
			op_if.valid <= 1'b0;
			@(posedge clk);
		end
		op_if.valid <= 1'b1;
		op_if.x_value <= x;
		do @(posedge clk); while (!op_if.ready);
		pending_roots.push_back(want);
		operands_sent++;
	endtask

	// Drop valid and hold until every root has been returned.
	task automatic wait_roots_done();
		op_if.valid <= 1'b0;
		while (pending_roots.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write, then read back in a second back-to-back transfer.
	task automatic write_tolerance(input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= TOL_ADDR;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tol_shadow = v;
		tol_writes++;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		rd = prdata;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== v)
			note_mismatch($sformatf("tolerance read back %h, wrote %h", rd, v));
	endtask

	initial begin
		res_if.ready = 1'b0;
		hold_left = 0;
		holds_taken = 0;
		forever begin
			@(posedge clk);
			if (hold_asks != holds_taken) begin
				holds_taken = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct(pace));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			got_root.root = res_if.root;
			got_root.guess_count = res_if.guess_count;
			got_root.converged = res_if.converged;
			roots_seen++;
			if (!res_if.converged)
				roots_capped++;
			if (pending_roots.size() == 0) begin
				note_mismatch($sformatf("unexpected root %h", got_root.root));
			end else begin
				want_root = pending_roots.pop_front();
				if (got_root.root !== want_root.root)
					note_mismatch($sformatf("root %h, want %h",
						got_root.root, want_root.root));
				if (got_root.guess_count !== want_root.guess_count)
					note_mismatch($sformatf("guess_count %0d, want %0d (root %h)",
						got_root.guess_count, want_root.guess_count, want_root.root));
				if (got_root.converged !== want_root.converged)
					note_mismatch($sformatf("converged %b, want %b (root %h)",
						got_root.converged, want_root.converged, want_root.root));
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready)
					|| (psel && penable && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		script_row_t row;
		logic [DATA_W-1:0] x;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		op_if.valid = 1'b0;
		op_if.x_value = '0;
		tol_shadow = TOL_RESET;
		pace = PH_STEADY;
		mismatches = 0;
		operands_sent = 0;
		tol_writes = 0;
		roots_seen = 0;
		roots_capped = 0;
		hold_asks = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < SCRIPT_LEN; i++) begin
			row = SCRIPT[i];
			if (row.kind == ROW_TOLERANCE) begin
				wait_roots_done();
				write_tolerance(row.value);
			end else begin
				send_operand(row.value,
					row.typed ? row.want : bisect_root(row.value, tol_shadow));
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			wait_roots_done();
			pace = pace_t'(p % 4);
			write_tolerance(phase_tolerance(p));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// stall the result side long enough to back up the operand side
				if (p == 0 && n == 60)
					hold_asks++;
				if (p == 4 && n == 100)
					wait_roots_done();
				x = pick_operand();
				send_operand(x, bisect_root(x, tol_shadow));
			end
		end

		wait_roots_done();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d operands through %0d tolerance writes, zero and all-ones included.",
			operands_sent, tol_writes);
		$display("Checked %0d roots: %0d converged, %0d stopped at the guess cap.",
			roots_seen, roots_seen - roots_capped, roots_capped);
		if (mismatches == 0 && pending_roots.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
